[sv/sfb_pkg.sv]
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants of the serial frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int ID_W  = 8;
    localparam int LEN_W = 16;
    localparam int BYTE_W = 8;
    localparam int IDX_W = 3;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [BYTE_W-1:0] SYNC_A        = 8'd254;
    localparam logic [BYTE_W-1:0] SYNC_B        = 8'd1;
    localparam logic [BYTE_W-1:0] SYNC_C        = 8'd255;
    localparam logic [BYTE_W-1:0] TEXT_ID_MAJOR = 8'd241;
    localparam logic [BYTE_W-1:0] TEXT_ID_MINOR = 8'd1;
    localparam logic [BYTE_W-1:0] TEXT_TRAILER  = 8'd0;

    // byte positions inside the result run of one item
    localparam logic [IDX_W-1:0] IDX_SYNC_A  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SYNC_B  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_SYNC_C  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_ID_MAJ  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_ID_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LEN_LO  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_LEN_HI  = 3'd6;
    localparam logic [IDX_W-1:0] IDX_HDR_TRL = 3'd7;
    localparam logic [IDX_W-1:0] IDX_PAY     = 3'd0;
    localparam logic [IDX_W-1:0] IDX_PAY_TRL = 3'd1;

    typedef struct packed {
        logic              action;
        logic              text_frame;
        logic [ID_W-1:0]   msg_id_major;
        logic [ID_W-1:0]   msg_id_minor;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] payload_byte;
    } t_item;

endpackage

[sv/sfb_in_stage.sv]
// ----------------------------------------------------------------------------
// sfb_in_stage
// Input register: holds one item until the byte engine has finished it.
// ----------------------------------------------------------------------------
module sfb_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // msg_id_major[7:0], msg_id_minor[15:8], payload_length[31:16],
    // payload_byte[39:32]
    input  logic [sfb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // action[0], text_frame[1]
    input  logic [sfb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                           i_take,
    output logic                           o_vld,
    output sfb_pkg::t_item                 o_item
);

    logic           r_vld;
    sfb_pkg::t_item r_item;

    assign s_axis_tready = !r_vld || i_take;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.action         <= s_axis_tuser[0];
            r_item.text_frame     <= s_axis_tuser[1];
            r_item.msg_id_major   <= s_axis_tdata[7:0];
            r_item.msg_id_minor   <= s_axis_tdata[15:8];
            r_item.payload_length <= s_axis_tdata[31:16];
            r_item.payload_byte   <= s_axis_tdata[39:32];
        end
    end

endmodule

[sv/sfb_engine.sv]
// ----------------------------------------------------------------------------
// sfb_engine
// Frame state, byte selection, checksum and the output byte register.
// ----------------------------------------------------------------------------
module sfb_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  sfb_pkg::t_item                 i_item,
    output logic                           o_take,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0]
    output logic [sfb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // frame_end[0]
    output logic [sfb_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic                             r_open;
    logic                             r_text;
    logic [sfb_pkg::LEN_W-1:0]        r_left;
    logic [sfb_pkg::BYTE_W-1:0]       r_sum;
    logic [sfb_pkg::IDX_W-1:0]        r_idx;
    logic                             r_out_vld;
    logic [sfb_pkg::BYTE_W-1:0]       r_out_byte;
    logic                             r_out_end;
    logic                             r_out_last;

    logic                             is_start;
    logic                             out_free;
    logic                             adv;
    logic                             drop;
    logic                             trailer;
    logic                             last;
    logic [sfb_pkg::BYTE_W-1:0]       trl_byte;
    logic [sfb_pkg::BYTE_W-1:0]       hdr_byte;
    logic [sfb_pkg::BYTE_W-1:0]       emit_byte;
    logic [sfb_pkg::BYTE_W-1:0]       sum_base;

    always_comb begin
        is_start = (i_item.action == sfb_pkg::ACT_START);
        out_free = !r_out_vld || m_axis_tready;
        adv      = i_vld && out_free;
        drop     = !is_start && !r_open;
        trl_byte = r_text ? sfb_pkg::TEXT_TRAILER : r_sum;

        unique case (r_idx)
            sfb_pkg::IDX_SYNC_A: hdr_byte = sfb_pkg::SYNC_A;
            sfb_pkg::IDX_SYNC_B: hdr_byte = sfb_pkg::SYNC_B;
            sfb_pkg::IDX_SYNC_C: hdr_byte = sfb_pkg::SYNC_C;
            sfb_pkg::IDX_ID_MAJ: hdr_byte = i_item.text_frame ? sfb_pkg::TEXT_ID_MAJOR
                                                              : i_item.msg_id_major;
            sfb_pkg::IDX_ID_MIN: hdr_byte = i_item.text_frame ? sfb_pkg::TEXT_ID_MINOR
                                                              : i_item.msg_id_minor;
            sfb_pkg::IDX_LEN_LO: hdr_byte = i_item.payload_length[7:0];
            sfb_pkg::IDX_LEN_HI: hdr_byte = i_item.payload_length[15:8];
            default:             hdr_byte = trl_byte;
        endcase

        if (is_start) begin
            trailer   = (r_idx == sfb_pkg::IDX_HDR_TRL);
            last      = (i_item.payload_length == '0) ? trailer
                                                      : (r_idx == sfb_pkg::IDX_LEN_HI);
            emit_byte = hdr_byte;
        end else begin
            trailer   = (r_idx == sfb_pkg::IDX_PAY_TRL);
            // the payload byte ends the item unless it is the last one expected, then the trailer follows
            last      = trailer || (r_left != sfb_pkg::LEN_W'(1));
            emit_byte = trailer ? trl_byte : i_item.payload_byte;
        end

        sum_base = (is_start && r_idx == sfb_pkg::IDX_SYNC_A) ? '0 : r_sum;
        o_take   = adv && (drop || last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_text    <= 1'b0;
            r_left    <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv && !drop) begin
                r_out_vld <= 1'b1;
                r_sum     <= sum_base + emit_byte;
                r_idx     <= last ? '0 : r_idx + sfb_pkg::IDX_W'(1);
                if (is_start && r_idx == sfb_pkg::IDX_SYNC_A) begin
                    r_text <= i_item.text_frame;
                    r_open <= 1'b1;
                    r_left <= i_item.payload_length;
                end
                if (!is_start && r_idx == sfb_pkg::IDX_PAY) begin
                    r_left <= r_left - sfb_pkg::LEN_W'(1);
                end
                if (trailer) begin
                    r_open <= 1'b0;
                    r_left <= '0;
                end
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (adv && !drop) begin
            r_out_byte <= emit_byte;
            r_out_end  <= trailer;
            r_out_last <= last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_end;
    assign m_axis_tlast  = r_out_last;

endmodule

[sv/serial_frame_builder.sv]
// ----------------------------------------------------------------------------
// serial_frame_builder
// Builds outgoing serial frames one byte per output transfer.
// ----------------------------------------------------------------------------
// A start item sends the header 254, 1, 255, id1, id2, length low, length
// high, and a zero-length frame closes right away with its trailer. Payload
// items pass one byte through; the payload that completes the frame adds the
// trailer (8-bit sum of header and payload for data frames, zero for text
// frames, whose ids are fixed to 241 and 1). tlast marks the last byte caused
// by each input item, tuser the last byte of a frame. The single output byte
// register paces the block: a payload item yields one byte (two when it closes
// the frame), a start item seven bytes (eight for zero length), a payload with
// no open frame is dropped without output, all subject to output backpressure.
// ----------------------------------------------------------------------------
module serial_frame_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // msg_id_major[7:0], msg_id_minor[15:8], payload_length[31:16],
    // payload_byte[39:32]
    input  logic [sfb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // action[0], text_frame[1]
    input  logic [sfb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0]
    output logic [sfb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // frame_end[0]
    output logic [sfb_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic           item_vld;
    logic           item_take;
    sfb_pkg::t_item item;

    sfb_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (item_take),
        .o_vld         (item_vld),
        .o_item        (item)
    );

    sfb_engine u_eng (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (item_vld),
        .i_item        (item),
        .o_take        (item_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
